/* rtl/ascii_frame_xor_checker_assert.svh */
`ifndef ASCII_FRAME_XOR_CHECKER_ASSERT_SVH
`define ASCII_FRAME_XOR_CHECKER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define AFXC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("afxc assertion failed");

// next-cycle implication, checked out of reset
`define AFXC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("afxc assertion failed");

`endif

/* rtl/afxc_pkg.sv */
`timescale 1ns / 1ps

package afxc_pkg;

  localparam int unsigned AFXC_MAX_FRAME_DEF = 65535;

  localparam int unsigned PREFIX_LEN = 11;
  localparam int unsigned MIN_SPACES = 3;
  localparam int unsigned MIN_LINE   = 5;

  localparam logic [7:0] CH_SOH   = 8'h01;
  localparam logic [7:0] CH_EOT   = 8'h04;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] STATUS_GOOD     = 2'd0;
  localparam logic [1:0] STATUS_INVALID  = 2'd1;
  localparam logic [1:0] STATUS_MISMATCH = 2'd2;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  computed_check;
    logic [7:0]  received_check;
    logic [15:0] frame_length;
  } afxc_result_t;

  // expected header prefix, one character per position
  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h4B;
      4'd1:    c = 8'h52;
      4'd2:    c = 8'h41;
      4'd3:    c = 8'h4D;
      4'd4:    c = 8'h53;
      4'd5:    c = 8'h20;
      4'd6:    c = 8'h56;
      4'd7:    c = 8'h32;
      4'd8:    c = 8'h2E;
      4'd9:    c = 8'h30;
      4'd10:   c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [9:0] digit_val(input logic [7:0] c);
    logic [7:0] d;
    d = c - CH_ZERO;
    return {6'd0, d[3:0]};
  endfunction

endpackage

/* rtl/ascii_frame_xor_checker.sv */
// one byte per cycle while the result register has space, accepted whenever the input register is free or draining
// result valid once the byte that ends the frame has passed through the input register
// into the result register, which loads the result when that byte is consumed
// a stalled result holds the parser, the input register still takes one more byte
// rst_ni clears the parser to idle awaiting SOH and empties both registers at once
`timescale 1ns / 1ps

module ascii_frame_xor_checker import afxc_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = AFXC_MAX_FRAME_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  computed_check_o,
  output logic [7:0]  received_check_o,
  output logic [15:0] frame_length_o
);

  logic         byte_valid;
  logic [7:0]   byte_val;
  logic         out_space;
  logic         consume;
  logic         emit;
  afxc_result_t fsm_result;
  afxc_result_t out_result;

  assign consume = byte_valid && out_space;

  afxc_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_valid_i   (rx_valid_i),
    .rx_ready_o   (rx_ready_o),
    .rx_byte_i    (rx_byte_i),
    .take_i       (consume),
    .byte_valid_o (byte_valid),
    .byte_o       (byte_val)
  );

  afxc_frame_fsm #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .consume_i (consume),
    .byte_i    (byte_val),
    .emit_o    (emit),
    .result_o  (fsm_result)
  );

  afxc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (consume && emit),
    .result_i    (fsm_result),
    .space_o     (out_space),
    .res_valid_o (res_valid_o),
    .res_ready_i (res_ready_i),
    .result_o    (out_result)
  );

  assign status_o         = out_result.status;
  assign computed_check_o = out_result.computed_check;
  assign received_check_o = out_result.received_check;
  assign frame_length_o   = out_result.frame_length;

endmodule

/* rtl/afxc_in_stage.sv */
`timescale 1ns / 1ps

module afxc_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       take_i,
  output logic       byte_valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  assign rx_ready_o   = !valid_q || take_i;
  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rx_valid_i && rx_ready_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_valid_i && rx_ready_o) begin
      byte_q <= rx_byte_i;
    end
  end

endmodule

/* rtl/afxc_frame_fsm.sv */
`timescale 1ns / 1ps

`include "ascii_frame_xor_checker_assert.svh"

module afxc_frame_fsm import afxc_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = AFXC_MAX_FRAME_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         consume_i,
  input  logic [7:0]   byte_i,
  output logic         emit_o,
  output afxc_result_t result_o
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_HEADER  = 3'd1;
  localparam logic [2:0] PH_HDR_LF  = 3'd2;
  localparam logic [2:0] PH_DATA    = 3'd3;
  localparam logic [2:0] PH_DATA_LF = 3'd4;
  localparam logic [2:0] PH_EOT     = 3'd5;

  localparam logic [15:0] MaxCount = 16'(MAX_FRAME_BYTES);

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  match_idx_q, match_idx_d;
  logic [1:0]  space_cnt_q, space_cnt_d;
  logic        hdr_good_q, hdr_good_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  tail_q [4];
  logic [7:0]  tail_d [4];
  logic [2:0]  line_cnt_q, line_cnt_d;
  logic [15:0] count_q, count_d;

  logic [15:0] count_inc;
  logic [9:0]  digits_sum;
  logic [7:0]  recv_val;
  logic        emit;
  afxc_result_t res;

  assign count_inc = (count_q < MaxCount) ? count_q + 16'd1 : count_q;

  // check digits with leading spaces skipped
  always_comb begin
    digits_sum = 10'd0;
    if (tail_q[1] == CH_SPACE && tail_q[2] == CH_SPACE && tail_q[3] == CH_SPACE) begin
      digits_sum = 10'd0;
    end else if (tail_q[1] == CH_SPACE && tail_q[2] == CH_SPACE) begin
      if (is_digit(tail_q[3])) begin
        digits_sum = digit_val(tail_q[3]);
      end
    end else if (tail_q[1] == CH_SPACE) begin
      if (is_digit(tail_q[2]) && is_digit(tail_q[3])) begin
        digits_sum = digit_val(tail_q[2]) * 10'd10 + digit_val(tail_q[3]);
      end
    end else if (is_digit(tail_q[1]) && is_digit(tail_q[2]) && is_digit(tail_q[3])) begin
      digits_sum = digit_val(tail_q[1]) * 10'd100 + digit_val(tail_q[2]) * 10'd10
                   + digit_val(tail_q[3]);
    end
    recv_val = digits_sum[7:0];
  end

  always_comb begin
    phase_d     = phase_q;
    match_idx_d = match_idx_q;
    space_cnt_d = space_cnt_q;
    hdr_good_d  = hdr_good_q;
    xor_d       = xor_q;
    tail_d      = tail_q;
    line_cnt_d  = line_cnt_q;
    count_d     = count_inc;
    emit        = 1'b0;
    res.status         = STATUS_INVALID;
    res.computed_check = xor_q;
    res.received_check = 8'd0;
    res.frame_length   = count_inc;

    case (phase_q)
      PH_IDLE: begin
        if (byte_i == CH_SOH) begin
          phase_d    = PH_HEADER;
          hdr_good_d = 1'b1;
          count_d    = 16'd1;
        end else begin
          emit               = 1'b1;
          res.computed_check = 8'd0;
          res.frame_length   = 16'd1;
        end
      end
      PH_HEADER: begin
        if (byte_i == CH_CR) begin
          if (match_idx_q < 4'(PREFIX_LEN) || space_cnt_q < 2'(MIN_SPACES)) begin
            hdr_good_d = 1'b0;
          end
          phase_d = PH_HDR_LF;
        end else if (byte_i == CH_LF) begin
          emit = 1'b1;
        end else begin
          if (match_idx_q < 4'(PREFIX_LEN)) begin
            if (byte_i != prefix_char(match_idx_q)) begin
              hdr_good_d = 1'b0;
            end
            match_idx_d = match_idx_q + 4'd1;
          end
          if (byte_i == CH_SPACE && space_cnt_q != 2'(MIN_SPACES)) begin
            space_cnt_d = space_cnt_q + 2'd1;
          end
        end
      end
      PH_HDR_LF: begin
        if (byte_i != CH_LF) begin
          emit = 1'b1;
        end else begin
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        if (byte_i == CH_CR) begin
          phase_d = PH_DATA_LF;
        end else if (byte_i == CH_LF) begin
          phase_d = PH_EOT;
        end else begin
          if (line_cnt_q != 3'd0) begin
            if (line_cnt_q >= 3'(MIN_LINE)) begin
              xor_d = xor_q ^ tail_q[0];
            end
            tail_d[0] = tail_q[1];
            tail_d[1] = tail_q[2];
            tail_d[2] = tail_q[3];
            tail_d[3] = byte_i;
          end
          if (line_cnt_q < 3'(MIN_LINE)) begin
            line_cnt_d = line_cnt_q + 3'd1;
          end
        end
      end
      PH_DATA_LF: begin
        if (byte_i != CH_LF) begin
          emit = 1'b1;
        end else begin
          phase_d = PH_EOT;
        end
      end
      PH_EOT: begin
        emit = 1'b1;
        if (byte_i == CH_EOT && line_cnt_q >= 3'(MIN_LINE)) begin
          res.received_check = recv_val;
          if (!hdr_good_q) begin
            res.status = STATUS_INVALID;
          end else if (recv_val != xor_q) begin
            res.status = STATUS_MISMATCH;
          end else begin
            res.status = STATUS_GOOD;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    // every result ends the frame
    if (emit) begin
      phase_d     = PH_IDLE;
      match_idx_d = 4'd0;
      space_cnt_d = 2'd0;
      hdr_good_d  = 1'b0;
      xor_d       = 8'd0;
      tail_d      = '{default: 8'd0};
      line_cnt_d  = 3'd0;
      count_d     = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      match_idx_q <= 4'd0;
      space_cnt_q <= 2'd0;
      hdr_good_q  <= 1'b0;
      xor_q       <= 8'd0;
      tail_q      <= '{default: 8'd0};
      line_cnt_q  <= 3'd0;
      count_q     <= 16'd0;
    end else if (consume_i) begin
      phase_q     <= phase_d;
      match_idx_q <= match_idx_d;
      space_cnt_q <= space_cnt_d;
      hdr_good_q  <= hdr_good_d;
      xor_q       <= xor_d;
      tail_q      <= tail_d;
      line_cnt_q  <= line_cnt_d;
      count_q     <= count_d;
    end
  end

  assign emit_o   = emit;
  assign result_o = res;

  `AFXC_ASSERT_NOW(a_good_means_match, consume_i && emit && res.status == STATUS_GOOD,
                   res.computed_check == res.received_check)
  `AFXC_ASSERT_NOW(a_idle_reject_len, consume_i && emit && phase_q == PH_IDLE,
                   res.frame_length == 16'd1 && res.computed_check == 8'd0)
  `AFXC_ASSERT_NEXT(a_result_ends_frame, consume_i && emit, phase_q == PH_IDLE && count_q == 16'd0)
  `AFXC_ASSERT_NOW(a_line_cnt_sat, 1'b1, line_cnt_q <= 3'(MIN_LINE))
  `AFXC_ASSERT_NOW(a_match_idx_sat, 1'b1, match_idx_q <= 4'(PREFIX_LEN))

endmodule

/* rtl/afxc_out_stage.sv */
`timescale 1ns / 1ps

module afxc_out_stage import afxc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  afxc_result_t result_i,
  output logic         space_o,
  output logic         res_valid_o,
  input  logic         res_ready_i,
  output afxc_result_t result_o
);

  logic         valid_q;
  afxc_result_t result_q;

  assign space_o     = !valid_q || res_ready_i;
  assign res_valid_o = valid_q;
  assign result_o    = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (res_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule
